// File: hw/rtl/wve_container_deframer_defines.svh
// ---------------------------------------------------------------------------
// WVE container deframer assertion macros
// Shared property wrappers for the deframer RTL; clk and rst_n are taken
// from the scope of the module that uses them.
// ---------------------------------------------------------------------------
`ifndef WVE_CONTAINER_DEFRAMER_DEFINES_SVH
`define WVE_CONTAINER_DEFRAMER_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define WVECD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset
`define WVECD_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/wvecd_pkg.sv
// ---------------------------------------------------------------------------
// WVE container deframer package
// Phase encoding, container tags, status codes and the result word type.
// ---------------------------------------------------------------------------
package wvecd_pkg;

  // Parse phase
  typedef enum logic [3:0] {
    PH_SIG    = 4'd0,
    PH_HSIZE  = 4'd1,
    PH_TAG    = 4'd2,
    PH_ELEM   = 4'd3,
    PH_LEN    = 4'd4,
    PH_VAL    = 4'd5,
    PH_SKIP   = 4'd6,
    PH_PRE    = 4'd7,
    PH_BODY   = 4'd8,
    PH_END    = 4'd9,
    PH_BADTAG = 4'd10,
    PH_SHORT  = 4'd11
  } wvecd_phase_t;

  // Container framing constants
  localparam int unsigned PREAMBLE_BYTES = 8;
  localparam int unsigned FIELD_BYTES    = 4;
  localparam logic [31:0] TAG_PT00       = 32'h5054_0000;
  localparam logic [31:0] TAG_AUDIO      = 32'h5343_446C;
  localparam logic [31:0] TAG_ENDING     = 32'h5343_456C;

  // Header element tags
  localparam logic [7:0] ELEM_HDR_END   = 8'hFF;
  localparam logic [7:0] ELEM_AUDIO_SUB = 8'hFD;
  localparam logic [7:0] ELEM_CHANNELS  = 8'h82;
  localparam logic [7:0] ELEM_COMPRESS  = 8'h83;
  localparam logic [7:0] ELEM_SAMPLES   = 8'h85;
  localparam logic [7:0] ELEM_SUB_END   = 8'h8A;
  localparam logic [31:0] COMP_TYPE_OK  = 32'd7;

  // Status codes
  localparam logic [2:0] ST_HEADER = 3'd0;
  localparam logic [2:0] ST_DATA   = 3'd1;
  localparam logic [2:0] ST_END    = 3'd2;
  localparam logic [2:0] ST_BADTAG = 3'd3;
  localparam logic [2:0] ST_SHORT  = 3'd4;

  // One result word
  typedef struct packed {
    logic        payload_valid;
    logic [7:0]  payload_byte;
    logic        payload_last;
    logic [2:0]  status;
    logic        audio_present;
    logic [7:0]  channel_count;
    logic        compression_known;
    logic [31:0] sample_total;
  } wvecd_result_t;

endpackage

// File: hw/rtl/wvecd_in_if.sv
// ---------------------------------------------------------------------------
// WVE container deframer input channel
// Valid/ready channel carrying one file byte per word.
// ---------------------------------------------------------------------------
interface wvecd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink   (input valid, input data_byte, output ready);
endinterface

// File: hw/rtl/wvecd_out_if.sv
// ---------------------------------------------------------------------------
// WVE container deframer result channel
// Valid/ready channel carrying one result word per input byte.
// ---------------------------------------------------------------------------
interface wvecd_out_if;
  logic        valid;
  logic        ready;
  logic        payload_valid;
  logic [7:0]  payload_byte;
  logic        payload_last;
  logic [2:0]  status;
  logic        audio_present;
  logic [7:0]  channel_count;
  logic        compression_known;
  logic [31:0] sample_total;

  modport source (output valid, output payload_valid, output payload_byte,
                  output payload_last, output status, output audio_present,
                  output channel_count, output compression_known,
                  output sample_total, input ready);
  modport sink   (input valid, input payload_valid, input payload_byte,
                  input payload_last, input status, input audio_present,
                  input channel_count, input compression_known,
                  input sample_total, output ready);
endinterface

// File: hw/rtl/wvecd_parser.sv
// ---------------------------------------------------------------------------
// WVE container deframer parser
// Input byte register followed by the single-pass parse step that updates
// the container state and produces one result word per byte.
// ---------------------------------------------------------------------------
`include "wve_container_deframer_defines.svh"

module wvecd_parser (
  input  logic                    clk,
  input  logic                    rst_n,
  wvecd_in_if.sink                in_ch,
  output logic                    push_valid,
  output wvecd_pkg::wvecd_result_t push_data,
  input  logic                    push_ready
);
  import wvecd_pkg::*;

  // Input register
  logic       in_v_r;
  logic [7:0] byte_r;
  logic       step;

  // Parse state
  wvecd_phase_t phase_r, phase_nxt;
  logic [31:0]  pos_r, pos_nxt;
  logic [31:0]  hlen_r, hlen_nxt;
  logic [7:0]   ebl_r, ebl_nxt;
  logic [31:0]  eval_r, eval_nxt;
  logic [7:0]   etag_r, etag_nxt;
  logic         in_sub_r, in_sub_nxt;
  logic [63:0]  pre_r, pre_nxt;
  logic [31:0]  chunk_left_r, chunk_left_nxt;
  logic         chunk_audio_r, chunk_audio_nxt;
  logic         seen_r, seen_nxt;
  logic [7:0]   chan_r, chan_nxt;
  logic         comp_r, comp_nxt;
  logic [31:0]  samples_r, samples_nxt;

  // Step temporaries
  logic [31:0] pos_inc;
  logic [7:0]  ebl_inc;
  logic [31:0] chunk_dec;
  logic [31:0] pre_type;
  logic [31:0] pre_low;
  logic [31:0] pre_size;
  logic        fin;
  logic        start_pre;
  logic        pv, pl;
  logic [7:0]  pb;
  logic [2:0]  st;

  assign step        = in_v_r && push_ready;
  assign in_ch.ready = !in_v_r || push_ready;

  // Hold the incoming byte until the parse step takes it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_v_r <= in_ch.valid;
    end
    if (in_ch.ready && in_ch.valid) begin
      byte_r <= in_ch.data_byte;
    end
  end

  // Parse state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= PH_SIG;
      pos_r         <= '0;
      hlen_r        <= '0;
      ebl_r         <= '0;
      eval_r        <= '0;
      etag_r        <= '0;
      in_sub_r      <= 1'b0;
      pre_r         <= '0;
      chunk_left_r  <= '0;
      chunk_audio_r <= 1'b0;
      seen_r        <= 1'b0;
      chan_r        <= '0;
      comp_r        <= 1'b0;
      samples_r     <= '0;
    end else begin
      phase_r       <= phase_nxt;
      pos_r         <= pos_nxt;
      hlen_r        <= hlen_nxt;
      ebl_r         <= ebl_nxt;
      eval_r        <= eval_nxt;
      etag_r        <= etag_nxt;
      in_sub_r      <= in_sub_nxt;
      pre_r         <= pre_nxt;
      chunk_left_r  <= chunk_left_nxt;
      chunk_audio_r <= chunk_audio_nxt;
      seen_r        <= seen_nxt;
      chan_r        <= chan_nxt;
      comp_r        <= comp_nxt;
      samples_r     <= samples_nxt;
    end
  end

  // Advance the parse by one byte
  always_comb begin
    phase_nxt       = phase_r;
    pos_nxt         = pos_r;
    hlen_nxt        = hlen_r;
    ebl_nxt         = ebl_r;
    eval_nxt        = eval_r;
    etag_nxt        = etag_r;
    in_sub_nxt      = in_sub_r;
    pre_nxt         = pre_r;
    chunk_left_nxt  = chunk_left_r;
    chunk_audio_nxt = chunk_audio_r;
    seen_nxt        = seen_r;
    chan_nxt        = chan_r;
    comp_nxt        = comp_r;
    samples_nxt     = samples_r;

    pos_inc   = pos_r + 32'd1;
    ebl_inc   = ebl_r + 8'd1;
    chunk_dec = chunk_left_r - 32'd1;
    pre_type  = '0;
    pre_low   = '0;
    pre_size  = '0;
    fin       = 1'b0;
    start_pre = 1'b0;
    pv        = 1'b0;
    pl        = 1'b0;
    pb        = '0;

    if (step) begin
      // Count bytes until a terminal phase is reached
      if (phase_r != PH_END && phase_r != PH_BADTAG && phase_r != PH_SHORT) begin
        pos_nxt = pos_inc;
      end

      case (phase_r)
        PH_SIG: begin
          ebl_nxt = ebl_inc;
          if (ebl_inc >= 8'(FIELD_BYTES)) begin
            ebl_nxt   = '0;
            hlen_nxt  = '0;
            phase_nxt = PH_HSIZE;
          end
        end
        PH_HSIZE: begin
          case (ebl_r[1:0])
            2'd0:    hlen_nxt = hlen_r | {24'd0, byte_r};
            2'd1:    hlen_nxt = hlen_r | {16'd0, byte_r, 8'd0};
            2'd2:    hlen_nxt = hlen_r | {8'd0, byte_r, 16'd0};
            default: hlen_nxt = hlen_r | {byte_r, 24'd0};
          endcase
          ebl_nxt = ebl_inc;
          if (ebl_inc >= 8'(FIELD_BYTES)) begin
            ebl_nxt   = '0;
            eval_nxt  = '0;
            phase_nxt = PH_TAG;
          end
        end
        PH_TAG: begin
          eval_nxt = {eval_r[23:0], byte_r};
          ebl_nxt  = ebl_inc;
          if (ebl_inc >= 8'(FIELD_BYTES)) begin
            ebl_nxt   = '0;
            phase_nxt = (eval_nxt == TAG_PT00) ? PH_ELEM : PH_BADTAG;
          end
        end
        PH_ELEM: begin
          if (!in_sub_r && byte_r == ELEM_HDR_END) begin
            if (hlen_r > pos_inc) begin
              phase_nxt = PH_SKIP;
            end else begin
              start_pre = 1'b1;
            end
          end else if (!in_sub_r && byte_r == ELEM_AUDIO_SUB) begin
            in_sub_nxt = 1'b1;
            seen_nxt   = 1'b1;
          end else begin
            etag_nxt  = byte_r;
            phase_nxt = PH_LEN;
          end
        end
        PH_LEN: begin
          ebl_nxt  = byte_r;
          eval_nxt = '0;
          if (byte_r == 8'd0) begin
            fin = 1'b1;
          end else begin
            phase_nxt = PH_VAL;
          end
        end
        PH_VAL: begin
          eval_nxt = {eval_r[23:0], byte_r};
          ebl_nxt  = ebl_r - 8'd1;
          if (ebl_nxt == 8'd0) begin
            fin = 1'b1;
          end
        end
        PH_SKIP: begin
          if (pos_inc >= hlen_r) begin
            start_pre = 1'b1;
          end
        end
        PH_PRE: begin
          pre_nxt = {pre_r[55:0], byte_r};
          ebl_nxt = ebl_inc;
          if (ebl_inc >= 8'(PREAMBLE_BYTES)) begin
            pre_type = pre_nxt[63:32];
            pre_low  = pre_nxt[31:0];
            pre_size = {pre_low[7:0], pre_low[15:8], pre_low[23:16], pre_low[31:24]};
            if (pre_type == TAG_ENDING) begin
              phase_nxt = PH_END;
            end else if (pre_size < 32'(PREAMBLE_BYTES)) begin
              phase_nxt = PH_SHORT;
            end else begin
              chunk_left_nxt  = pre_size - 32'(PREAMBLE_BYTES);
              chunk_audio_nxt = (pre_type == TAG_AUDIO) && seen_r;
              if (pre_size == 32'(PREAMBLE_BYTES)) begin
                start_pre = 1'b1;
              end else begin
                phase_nxt = PH_BODY;
              end
            end
          end
        end
        PH_BODY: begin
          chunk_left_nxt = chunk_dec;
          if (chunk_audio_r) begin
            pv = 1'b1;
            pb = byte_r;
            pl = (chunk_dec == 32'd0);
          end
          if (chunk_dec == 32'd0) begin
            start_pre = 1'b1;
          end
        end
        default: begin
        end
      endcase

      // Close a header element; subheader fields land in the audio registers
      if (fin) begin
        if (in_sub_r) begin
          case (etag_r)
            ELEM_CHANNELS: chan_nxt = (eval_nxt > 32'd255) ? 8'd255 : eval_nxt[7:0];
            ELEM_COMPRESS: comp_nxt = (eval_nxt == COMP_TYPE_OK);
            ELEM_SAMPLES:  samples_nxt = eval_nxt;
            ELEM_SUB_END:  in_sub_nxt = 1'b0;
            default: begin
            end
          endcase
        end
        phase_nxt = PH_ELEM;
      end

      // Open a fresh chunk preamble
      if (start_pre) begin
        phase_nxt = PH_PRE;
        ebl_nxt   = '0;
        pre_nxt   = '0;
      end
    end

    // Status after this byte
    case (phase_nxt)
      PH_END:         st = ST_END;
      PH_BADTAG:      st = ST_BADTAG;
      PH_SHORT:       st = ST_SHORT;
      PH_PRE, PH_BODY: st = ST_DATA;
      default:        st = ST_HEADER;
    endcase

    push_data.payload_valid     = pv;
    push_data.payload_byte      = pb;
    push_data.payload_last      = pl;
    push_data.status            = st;
    push_data.audio_present     = seen_nxt;
    push_data.channel_count     = chan_nxt;
    push_data.compression_known = comp_nxt;
    push_data.sample_total      = samples_nxt;
  end

  assign push_valid = in_v_r;

  `WVECD_ASSERT_IMP(a_last_is_payload, push_valid && push_data.payload_last,
                    push_data.payload_valid, "payload_last without payload_valid")
  `WVECD_ASSERT_NXT(a_end_holds, phase_r == PH_END, phase_r == PH_END,
                    "left end-of-stream phase without reset")
  `WVECD_ASSERT_NXT(a_pos_frozen,
                    phase_r == PH_END || phase_r == PH_BADTAG || phase_r == PH_SHORT,
                    $stable(pos_r), "byte position moved in a terminal phase")
  `WVECD_ASSERT_IMP(a_payload_in_body, step && pv, phase_r == PH_BODY && chunk_audio_r,
                    "payload byte outside an audio chunk body")

endmodule

// File: hw/rtl/wvecd_out_buf.sv
// ---------------------------------------------------------------------------
// WVE container deframer result buffer
// Two-word registered buffer that decouples the parse step from the sink.
// ---------------------------------------------------------------------------
module wvecd_out_buf (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     push_valid,
  input  wvecd_pkg::wvecd_result_t push_data,
  output logic                     push_ready,
  wvecd_out_if.source              out_ch
);
  import wvecd_pkg::*;

  logic [1:0]    cnt_r, cnt_nxt;
  wvecd_result_t ent0_r, ent0_nxt;
  wvecd_result_t ent1_r, ent1_nxt;
  logic          push, pop;

  assign push_ready = (cnt_r != 2'd2);
  assign push       = push_valid && push_ready;
  assign pop        = out_ch.valid && out_ch.ready;

  // Fill, drain and shift the two entries
  always_comb begin
    cnt_nxt  = cnt_r;
    ent0_nxt = ent0_r;
    ent1_nxt = ent1_r;
    if (push && !pop) begin
      if (cnt_r == 2'd0) begin
        ent0_nxt = push_data;
      end else begin
        ent1_nxt = push_data;
      end
      cnt_nxt = cnt_r + 2'd1;
    end else if (pop && !push) begin
      ent0_nxt = ent1_r;
      cnt_nxt  = cnt_r - 2'd1;
    end else if (pop && push) begin
      ent0_nxt = push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
    ent0_r <= ent0_nxt;
    ent1_r <= ent1_nxt;
  end

  // Drive the head entry
  assign out_ch.valid             = (cnt_r != 2'd0);
  assign out_ch.payload_valid     = ent0_r.payload_valid;
  assign out_ch.payload_byte      = ent0_r.payload_byte;
  assign out_ch.payload_last      = ent0_r.payload_last;
  assign out_ch.status            = ent0_r.status;
  assign out_ch.audio_present     = ent0_r.audio_present;
  assign out_ch.channel_count     = ent0_r.channel_count;
  assign out_ch.compression_known = ent0_r.compression_known;
  assign out_ch.sample_total      = ent0_r.sample_total;

endmodule

// File: hw/rtl/wve_container_deframer.sv
// ---------------------------------------------------------------------------
// WVE container deframer
// Byte-serial parser for the chunked audio container.
// ---------------------------------------------------------------------------
// The block takes one file byte per cycle and returns exactly one result word
// for every byte, in order: a byte of an audio chunk body comes out with
// payload_valid set (payload_last on the final one), every other byte comes
// out with payload_valid clear, and each word carries the parse status and
// the audio subheader fields as they stand after that byte. Sustained rate is
// one byte per clock. An accepted byte sits in the input byte register until
// the parse step takes it, and its result word is then written into the
// two-word result buffer, whose head entry drives the result channel.
// The parse state is one register set updated once per byte, so back pressure
// on the result side stalls input only after both buffer words fill. Status
// codes end tag, bad header tag and chunk too short are sticky until reset.
module wve_container_deframer (
  input  logic        clk,
  input  logic        rst_n,
  wvecd_in_if.sink    in_ch,
  wvecd_out_if.source out_ch
);
  import wvecd_pkg::*;

  logic          push_valid;
  logic          push_ready;
  wvecd_result_t push_data;

  // Parse one byte per cycle while the result buffer has room
  wvecd_parser u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .push_valid (push_valid),
    .push_data  (push_data),
    .push_ready (push_ready)
  );

  // Buffer result words toward the sink
  wvecd_out_buf u_out_buf (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_data  (push_data),
    .push_ready (push_ready),
    .out_ch     (out_ch)
  );

endmodule
